/* rtl/core/mesh_tangent_accumulator_assert.svh */
// Assertion macros shared by the mesh tangent accumulator RTL.
`ifndef MESH_TANGENT_ACCUMULATOR_ASSERT_SVH
`define MESH_TANGENT_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MTA_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("mesh_tangent_accumulator: check failed");

// Next-cycle implication, checked out of reset.
`define MTA_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("mesh_tangent_accumulator: check failed");

`endif

/* rtl/core/mta_pkg.sv */
// Types, constants and helpers shared by the mesh tangent accumulator.
package mta_pkg;

  localparam int VERTEX_COUNT = 1024;
  localparam int IDX_W        = $clog2(VERTEX_COUNT);
  localparam int CNT_W        = (IDX_W > 7) ? IDX_W : 7;
  localparam int DIV_STEPS    = 80;
  localparam int SQRT_STEPS   = 32;

  // command codes
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_TRI  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // corner / address selects
  localparam logic [1:0] SEL_A   = 2'd0;
  localparam logic [1:0] SEL_B   = 2'd1;
  localparam logic [1:0] SEL_C   = 2'd2;
  localparam logic [1:0] SEL_REQ = 2'd3;

  // multiplier operand selects
  localparam logic [3:0] MS_DU1DV2 = 4'd0;
  localparam logic [3:0] MS_DU2DV1 = 4'd1;
  localparam logic [3:0] MS_DV2E1X = 4'd2;
  localparam logic [3:0] MS_DV1E2X = 4'd3;
  localparam logic [3:0] MS_DV2E1Y = 4'd4;
  localparam logic [3:0] MS_DV1E2Y = 4'd5;
  localparam logic [3:0] MS_DV2E1Z = 4'd6;
  localparam logic [3:0] MS_DV1E2Z = 4'd7;
  localparam logic [3:0] MS_SQX    = 4'd8;
  localparam logic [3:0] MS_SQY    = 4'd9;
  localparam logic [3:0] MS_SQZ    = 4'd10;

  localparam logic signed [31:0] SAT31 = 32'sh7FFF_FFFF;
  localparam logic signed [47:0] SAT48 = 48'sh7FFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]         command;
    logic [9:0]         vertex_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
    logic [9:0]         corner_a;
    logic [9:0]         corner_b;
    logic [9:0]         corner_c;
  } in_t;

  typedef struct packed {
    logic [9:0]         read_index;
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_y;
    logic signed [15:0] tangent_z;
    logic               degenerate;
  } out_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
  } vtx_t;

  typedef struct packed {
    logic signed [47:0] x;
    logic signed [47:0] y;
    logic signed [47:0] z;
  } sum_t;

  typedef struct packed {
    logic             req_ld;
    logic             vwr;
    logic             vrd;
    logic [1:0]       vrd_sel;
    logic             vcap;
    logic [1:0]       vcap_sel;
    logic             delta_ld;
    logic             mul_en;
    logic [3:0]       mul_sel;
    logic             acc_en;
    logic [3:0]       acc_sel;
    logic             div_init;
    logic             div_step;
    logic             div_fin;
    logic             div_read;
    logic [1:0]       div_k;
    logic             srd;
    logic [1:0]       srd_sel;
    logic             sum_wr;
    logic [1:0]       sum_wr_sel;
    logic             clr_wr;
    logic [IDX_W-1:0] clr_addr;
    logic             mag_ld;
    logic             norm_shr;
    logic             norm_shl;
    logic             sq_init;
    logic             sq_step;
    logic             res_fire;
  } dp_cmd_t;

  typedef struct packed {
    logic det_zero;
    logic m_zero;
    logic m_hi;
    logic m_lo;
  } dp_stat_t;

  function automatic logic signed [31:0] sat_sub32(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    if (d > 33'(SAT31)) return SAT31;
    if (d < -33'(SAT31)) return -SAT31;
    return d[31:0];
  endfunction

  function automatic logic signed [47:0] sat_add48(input logic signed [47:0] a,
                                                   input logic signed [47:0] b);
    logic signed [48:0] s;
    s = 49'(a) + 49'(b);
    if (s > 49'(SAT48)) return SAT48;
    if (s < -49'(SAT48)) return -SAT48;
    return s[47:0];
  endfunction

endpackage

/* rtl/core/mta_ctrl.sv */
// Sequencer for the mesh tangent accumulator.
module mta_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [1:0]            command,
  input  mta_pkg::dp_stat_t     stat,
  output logic                  busy,
  output mta_pkg::dp_cmd_t      cmd
);

  typedef enum logic [17:0] {
    S_CLEAR    = 18'h00001,
    S_IDLE     = 18'h00002,
    S_LOAD     = 18'h00004,
    S_VRD      = 18'h00008,
    S_DELTA    = 18'h00010,
    S_MUL      = 18'h00020,
    S_DIV_INIT = 18'h00040,
    S_DIV      = 18'h00080,
    S_DIV_FIN  = 18'h00100,
    S_SUM_RD   = 18'h00200,
    S_SUM_WR   = 18'h00400,
    S_RD_SUM   = 18'h00800,
    S_RD_CAP   = 18'h01000,
    S_NORM     = 18'h02000,
    S_SQ_MUL   = 18'h04000,
    S_SQ_INIT  = 18'h08000,
    S_SQ       = 18'h10000,
    S_OUT      = 18'h20000
  } state_t;

  state_t                    state, state_next;
  logic [mta_pkg::CNT_W-1:0] cnt, cnt_next;
  logic [1:0]                k, k_next;
  logic                      rd_mode, rd_mode_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      cnt     <= '0;
      k       <= '0;
      rd_mode <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      k       <= k_next;
      rd_mode <= rd_mode_next;
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    k_next       = k;
    rd_mode_next = rd_mode;
    cmd          = '0;
    cmd.clr_addr   = cnt[mta_pkg::IDX_W-1:0];
    cmd.vrd_sel    = cnt[1:0];
    cmd.vcap_sel   = cnt[1:0] - 2'd1;
    cmd.div_read   = rd_mode;
    cmd.div_k      = k;
    cmd.srd_sel    = k;
    cmd.sum_wr_sel = k;
    cmd.mul_sel    = mta_pkg::MS_DU1DV2 + cnt[3:0];
    cmd.acc_sel    = mta_pkg::MS_DU1DV2 + cnt[3:0] - 4'd1;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (cnt == mta_pkg::CNT_W'(mta_pkg::VERTEX_COUNT - 1)) begin
          state_next = S_IDLE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.req_ld   = 1'b1;
          cnt_next     = '0;
          k_next       = '0;
          rd_mode_next = 1'b0;
          unique case (command)
            mta_pkg::CMD_LOAD: state_next = S_LOAD;
            mta_pkg::CMD_TRI:  state_next = S_VRD;
            mta_pkg::CMD_READ: begin
              rd_mode_next = 1'b1;
              state_next   = S_RD_SUM;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        cmd.vwr    = 1'b1;
        state_next = S_IDLE;
      end
      S_VRD: begin
        cmd.vrd  = (cnt != mta_pkg::CNT_W'(3));
        cmd.vcap = (cnt != '0);
        if (cnt == mta_pkg::CNT_W'(3)) state_next = S_DELTA;
        else cnt_next = cnt + 1'b1;
      end
      S_DELTA: begin
        cmd.delta_ld = 1'b1;
        cnt_next     = '0;
        state_next   = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = (cnt != mta_pkg::CNT_W'(8));
        cmd.acc_en = (cnt != '0);
        if (cnt == mta_pkg::CNT_W'(8)) begin
          k_next     = '0;
          state_next = stat.det_zero ? S_IDLE : S_DIV_INIT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == mta_pkg::CNT_W'(mta_pkg::DIV_STEPS - 1)) state_next = S_DIV_FIN;
        else cnt_next = cnt + 1'b1;
      end
      S_DIV_FIN: begin
        cmd.div_fin = 1'b1;
        if (k == mta_pkg::SEL_C) begin
          k_next     = '0;
          state_next = rd_mode ? S_OUT : S_SUM_RD;
        end else begin
          k_next     = k + 2'd1;
          state_next = S_DIV_INIT;
        end
      end
      S_SUM_RD: begin
        cmd.srd    = 1'b1;
        state_next = S_SUM_WR;
      end
      S_SUM_WR: begin
        cmd.sum_wr = 1'b1;
        if (k == mta_pkg::SEL_C) begin
          state_next = S_IDLE;
        end else begin
          k_next     = k + 2'd1;
          state_next = S_SUM_RD;
        end
      end
      S_RD_SUM: begin
        cmd.srd     = 1'b1;
        cmd.srd_sel = mta_pkg::SEL_REQ;
        state_next  = S_RD_CAP;
      end
      S_RD_CAP: begin
        cmd.mag_ld = 1'b1;
        state_next = S_NORM;
      end
      S_NORM: begin
        if (stat.m_zero) begin
          state_next = S_OUT;
        end else if (stat.m_hi) begin
          cmd.norm_shr = 1'b1;
        end else if (stat.m_lo) begin
          cmd.norm_shl = 1'b1;
        end else begin
          cnt_next   = '0;
          state_next = S_SQ_MUL;
        end
      end
      S_SQ_MUL: begin
        cmd.mul_sel = mta_pkg::MS_SQX + cnt[3:0];
        cmd.acc_sel = mta_pkg::MS_SQX + cnt[3:0] - 4'd1;
        cmd.mul_en  = (cnt != mta_pkg::CNT_W'(3));
        cmd.acc_en  = (cnt != '0);
        if (cnt == mta_pkg::CNT_W'(3)) state_next = S_SQ_INIT;
        else cnt_next = cnt + 1'b1;
      end
      S_SQ_INIT: begin
        cmd.sq_init = 1'b1;
        cnt_next    = '0;
        state_next  = S_SQ;
      end
      S_SQ: begin
        cmd.sq_step = 1'b1;
        if (cnt == mta_pkg::CNT_W'(mta_pkg::SQRT_STEPS - 1)) begin
          k_next     = '0;
          state_next = S_DIV_INIT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_OUT: begin
        cmd.res_fire = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* rtl/core/mta_datapath.sv */
// Datapath: vertex and sum memories, shared multiplier, divider and square root.
`include "mesh_tangent_accumulator_assert.svh"
module mta_datapath (
  input  logic               clk,
  input  logic               rst,
  input  mta_pkg::in_t       request,
  input  mta_pkg::dp_cmd_t   cmd,
  output mta_pkg::dp_stat_t  stat,
  output mta_pkg::out_t      result,
  output logic               done
);

  localparam int IW   = mta_pkg::IDX_W;
  localparam int SS_W = 62;
  localparam int SQ_W = 63;

  mta_pkg::in_t  req;
  mta_pkg::vtx_t vmem [mta_pkg::VERTEX_COUNT];
  mta_pkg::vtx_t vrdata, ca, cb, cc;
  mta_pkg::sum_t smem [mta_pkg::VERTEX_COUNT];
  mta_pkg::sum_t srdata, swdata;
  logic          swe;
  logic [IW-1:0] swaddr, sraddr, vaddr;

  logic signed [31:0] e1x, e1y, e1z, e2x, e2y, e2z, du1, dv1, du2, dv2;
  logic signed [31:0] opa, opb;
  logic signed [63:0] prod, hold, det, nx, ny, nz;
  logic [SS_W-1:0]    ssum;

  logic [47:0] mx, my, mz, mmax;
  logic        sx, sy, sz;

  logic [SQ_W-1:0] sq_s, sq_res, sq_bit, sq_t;

  logic [63:0] dnum, drem, dden;
  logic [46:0] dq, dq_rnd;
  logic        dsat, dneg;
  logic [63:0] div_num_init, div_den_init;
  logic        div_neg_init;
  logic [64:0] rem_s;
  logic        div_ge;
  logic        round_up;
  logic signed [47:0] qval;
  logic signed [47:0] tx, ty, tz;
  logic signed [15:0] ox, oy, oz;
  logic        tan_zero;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [IW-1:0] corner(input mta_pkg::in_t r, input logic [1:0] s);
    logic [IW-1:0] a;
    case (s)
      mta_pkg::SEL_A: a = r.corner_a[IW-1:0];
      mta_pkg::SEL_B: a = r.corner_b[IW-1:0];
      mta_pkg::SEL_C: a = r.corner_c[IW-1:0];
      default:        a = r.vertex_index[IW-1:0];
    endcase
    return a;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.req_ld) req <= request;
  end

  // vertex store
  assign vaddr = corner(req, cmd.vrd_sel);

  always_ff @(posedge clk) begin
    if (cmd.vwr)
      vmem[req.vertex_index[IW-1:0]] <= '{req.pos_x, req.pos_y, req.pos_z,
                                          req.tex_u, req.tex_v};
    if (cmd.vrd) vrdata <= vmem[vaddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.vcap) begin
      case (cmd.vcap_sel)
        mta_pkg::SEL_A: ca <= vrdata;
        mta_pkg::SEL_B: cb <= vrdata;
        default:        cc <= vrdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.delta_ld) begin
      e1x <= mta_pkg::sat_sub32(cb.pos_x, ca.pos_x);
      e1y <= mta_pkg::sat_sub32(cb.pos_y, ca.pos_y);
      e1z <= mta_pkg::sat_sub32(cb.pos_z, ca.pos_z);
      e2x <= mta_pkg::sat_sub32(cc.pos_x, ca.pos_x);
      e2y <= mta_pkg::sat_sub32(cc.pos_y, ca.pos_y);
      e2z <= mta_pkg::sat_sub32(cc.pos_z, ca.pos_z);
      du1 <= mta_pkg::sat_sub32(cb.tex_u, ca.tex_u);
      dv1 <= mta_pkg::sat_sub32(cb.tex_v, ca.tex_v);
      du2 <= mta_pkg::sat_sub32(cc.tex_u, ca.tex_u);
      dv2 <= mta_pkg::sat_sub32(cc.tex_v, ca.tex_v);
    end
  end

  // shared 32x32 multiplier
  always_comb begin
    case (cmd.mul_sel)
      mta_pkg::MS_DU1DV2: begin opa = du1; opb = dv2; end
      mta_pkg::MS_DU2DV1: begin opa = du2; opb = dv1; end
      mta_pkg::MS_DV2E1X: begin opa = dv2; opb = e1x; end
      mta_pkg::MS_DV1E2X: begin opa = dv1; opb = e2x; end
      mta_pkg::MS_DV2E1Y: begin opa = dv2; opb = e1y; end
      mta_pkg::MS_DV1E2Y: begin opa = dv1; opb = e2y; end
      mta_pkg::MS_DV2E1Z: begin opa = dv2; opb = e1z; end
      mta_pkg::MS_DV1E2Z: begin opa = dv1; opb = e2z; end
      mta_pkg::MS_SQX:    begin opa = mx[31:0]; opb = mx[31:0]; end
      mta_pkg::MS_SQY:    begin opa = my[31:0]; opb = my[31:0]; end
      mta_pkg::MS_SQZ:    begin opa = mz[31:0]; opb = mz[31:0]; end
      default:            begin opa = '0; opb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod <= opa * opb;
    if (cmd.acc_en) begin
      case (cmd.acc_sel) inside
        mta_pkg::MS_DU1DV2, mta_pkg::MS_DV2E1X,
        mta_pkg::MS_DV2E1Y, mta_pkg::MS_DV2E1Z: hold <= prod;
        mta_pkg::MS_DU2DV1: det <= hold - prod;
        mta_pkg::MS_DV1E2X: nx  <= hold - prod;
        mta_pkg::MS_DV1E2Y: ny  <= hold - prod;
        mta_pkg::MS_DV1E2Z: nz  <= hold - prod;
        mta_pkg::MS_SQX:    ssum <= prod[SS_W-1:0];
        mta_pkg::MS_SQY, mta_pkg::MS_SQZ: ssum <= ssum + prod[SS_W-1:0];
        default: ;
      endcase
    end
  end

  // tangent sum store
  assign sraddr = corner(req, cmd.srd_sel);

  always_comb begin
    swe    = 1'b0;
    swaddr = corner(req, cmd.sum_wr_sel);
    swdata = '0;
    if (cmd.clr_wr) begin
      swe    = 1'b1;
      swaddr = cmd.clr_addr;
    end else if (cmd.vwr) begin
      swe    = 1'b1;
      swaddr = req.vertex_index[IW-1:0];
    end else if (cmd.sum_wr) begin
      swe      = 1'b1;
      swdata.x = mta_pkg::sat_add48(srdata.x, tx);
      swdata.y = mta_pkg::sat_add48(srdata.y, ty);
      swdata.z = mta_pkg::sat_add48(srdata.z, tz);
    end
  end

  always_ff @(posedge clk) begin
    if (swe) smem[swaddr] <= swdata;
    if (cmd.srd) srdata <= smem[sraddr];
  end

  // magnitude normalisation
  always_comb begin
    mmax = mx;
    if (my > mmax) mmax = my;
    if (mz > mmax) mmax = mz;
  end

  always_ff @(posedge clk) begin
    if (cmd.mag_ld) begin
      mx <= srdata.x[47] ? 48'(-srdata.x) : 48'(srdata.x);
      my <= srdata.y[47] ? 48'(-srdata.y) : 48'(srdata.y);
      mz <= srdata.z[47] ? 48'(-srdata.z) : 48'(srdata.z);
      sx <= srdata.x[47];
      sy <= srdata.y[47];
      sz <= srdata.z[47];
    end else if (cmd.norm_shr) begin
      mx <= mx >> 1;
      my <= my >> 1;
      mz <= mz >> 1;
    end else if (cmd.norm_shl) begin
      mx <= mx << 1;
      my <= my << 1;
      mz <= mz << 1;
    end
  end

  assign stat.det_zero = (det == '0);
  assign stat.m_zero   = (mmax == '0);
  assign stat.m_hi     = (mmax[47:30] != '0);
  assign stat.m_lo     = (mmax[47:29] == '0);

  // integer square root, one result bit and two radicand bits per step
  assign sq_t = sq_res + sq_bit;

  always_ff @(posedge clk) begin
    if (cmd.sq_init) begin
      sq_s   <= SQ_W'(ssum);
      sq_res <= '0;
      sq_bit <= SQ_W'(1) << (SQ_W - 1);
    end else if (cmd.sq_step) begin
      if (sq_s >= sq_t) begin
        sq_s   <= sq_s - sq_t;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end

  // restoring divider: round(num * 2^16 / den), saturating quotient
  always_comb begin
    logic [47:0] mk;
    logic        sk;
    logic signed [63:0] nk;
    case (cmd.div_k)
      mta_pkg::SEL_A: begin mk = mx; sk = sx; nk = nx; end
      mta_pkg::SEL_B: begin mk = my; sk = sy; nk = ny; end
      default:        begin mk = mz; sk = sz; nk = nz; end
    endcase
    if (cmd.div_read) begin
      div_num_init = 64'(mk);
      div_den_init = 64'({sq_res[30:0], 2'b00});
      div_neg_init = sk;
    end else begin
      div_num_init = mag64(nk);
      div_den_init = mag64(det);
      div_neg_init = nk[63] ^ det[63];
    end
  end

  assign rem_s    = {drem, dnum[63]};
  assign div_ge   = (rem_s >= {1'b0, dden});
  assign round_up = !dsat && ({drem, 1'b0} >= {1'b0, dden});
  assign dq_rnd   = (&dq) ? dq : dq + 47'(round_up);
  assign qval     = dneg ? -$signed({1'b0, dq_rnd}) : $signed({1'b0, dq_rnd});

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dnum <= div_num_init;
      dden <= div_den_init;
      drem <= '0;
      dq   <= '0;
      dsat <= 1'b0;
      dneg <= div_neg_init;
    end else if (cmd.div_step) begin
      dnum <= dnum << 1;
      drem <= div_ge ? 64'(rem_s - {1'b0, dden}) : rem_s[63:0];
      if (!dsat) begin
        if (dq[46]) begin
          dsat <= 1'b1;
          dq   <= '1;
        end else begin
          dq <= {dq[45:0], div_ge};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_fin) begin
      if (cmd.div_read) begin
        case (cmd.div_k)
          mta_pkg::SEL_A: ox <= qval[15:0];
          mta_pkg::SEL_B: oy <= qval[15:0];
          default:        oz <= qval[15:0];
        endcase
      end else begin
        case (cmd.div_k)
          mta_pkg::SEL_A: tx <= qval;
          mta_pkg::SEL_B: ty <= qval;
          default:        tz <= qval;
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_fire) begin
      result.read_index <= req.vertex_index;
      result.tangent_x  <= stat.m_zero ? 16'sd0 : ox;
      result.tangent_y  <= stat.m_zero ? 16'sd0 : oy;
      result.tangent_z  <= stat.m_zero ? 16'sd0 : oz;
      result.degenerate <= stat.m_zero;
    end
  end

  assign tan_zero = (result.tangent_x == 16'sd0) && (result.tangent_y == 16'sd0) &&
                    (result.tangent_z == 16'sd0);

  `MTA_ASSERT_NEXT(a_done_follows_fire, cmd.res_fire, done)
  `MTA_ASSERT_IMPL(a_degen_zero, done && result.degenerate, tan_zero)
  `MTA_ASSERT_IMPL(a_one_sum_writer, 1'b1, $countones({cmd.clr_wr, cmd.vwr, cmd.sum_wr}) <= 1)
  `MTA_ASSERT_IMPL(a_norm_in_band, cmd.mul_en && cmd.mul_sel == mta_pkg::MS_SQX, !stat.m_hi && !stat.m_lo)

endmodule

/* rtl/core/mesh_tangent_accumulator.sv */
// Top level of the mesh tangent accumulator: sequencer plus datapath.
//
//  channel  | ports                 | transfer
//  ---------+-----------------------+-------------------------------------
//  command  | start, busy, request  | at a clock edge with start=1, busy=0
//  result   | done, result          | every cycle with done=1, no stall
//
// After reset the tangent sum store is swept to zero, one entry a cycle;
// busy stays high during the sweep, before the first transfer.
// Triangle: fetch the corners and form the products on the one 32x32
// multiplier, then three divisions in the bit-serial divider and a
// read-modify-write of each corner's sum; a zero UV determinant ends
// after the products.
// Read: a normalising shift, the square root and the three output
// divisions; a zero sum skips the square root and the divisions.
// Results are shown for one cycle with done; the receiver cannot stall.
module mesh_tangent_accumulator (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  mta_pkg::in_t  request,
  output logic          done,
  output mta_pkg::out_t result
);

  mta_pkg::dp_cmd_t  cmd;
  mta_pkg::dp_stat_t stat;

  // sequencer: one command at a time, drives the datapath step by step
  mta_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (request.command),
    .stat    (stat),
    .busy    (busy),
    .cmd     (cmd)
  );

  // datapath: latches the request on transfer, owns all storage and arithmetic
  mta_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .result  (result),
    .done    (done)
  );

endmodule

/* tb/mesh_tangent_accumulator_tb.sv */
// Self-checking testbench for the mesh tangent accumulator.
`timescale 1ns / 1ps

module mesh_tangent_accumulator_tb;

  localparam int QUIET_LIMIT = 20000;  // reset sweep plus slowest read, many times over
  localparam longint LIM31 = 64'sd2147483647;
  localparam longint LIM47 = 64'sd140737488355327;
  localparam logic [1:0] CMD_SPARE = 2'd3;  // unused code, must be ignored

  // Tracks the vertex stores and tangent sums and queues the expected read-outs.
  class tangent_scoreboard;
    mta_pkg::vtx_t verts[mta_pkg::VERTEX_COUNT];
    longint sum_x[mta_pkg::VERTEX_COUNT], sum_y[mta_pkg::VERTEX_COUNT];
    longint sum_z[mta_pkg::VERTEX_COUNT];
    mta_pkg::out_t pending_tangents[$];
    int     errors;

    function automatic longint clip(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function automatic logic [63:0] mag(longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // |num| * 2^16 / |den|, nearest with ties away, saturating to 47 bits
    function automatic longint quot_q16(longint n, longint d);
      logic [127:0] numer, den, q, r;
      longint res;
      numer = {64'd0, mag(n)} << 16;
      den   = {64'd0, mag(d)};
      q = numer / den;
      r = numer % den;
      if (q > 128'(LIM47)) res = LIM47;
      else begin
        if ((r << 1) >= den) q = q + 1;
        res = (q > 128'(LIM47)) ? LIM47 : longint'(q[63:0]);
      end
      return ((n < 0) != (d < 0)) ? -res : res;
    endfunction

    function automatic logic [63:0] root(logic [63:0] s);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (s >= res + bitv) begin
          s = s - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function automatic logic [15:0] unit_comp(longint c, logic [63:0] m, logic [63:0] len);
      logic [63:0] o;
      o = (64'd32768 * m + len) / (len << 1);
      if (c < 0) o = -o;
      return o[15:0];
    endfunction

    function automatic void add_tangent(int i, longint tx, longint ty, longint tz);
      sum_x[i] = clip(sum_x[i] + tx, LIM47);
      sum_y[i] = clip(sum_y[i] + ty, LIM47);
      sum_z[i] = clip(sum_z[i] + tz, LIM47);
    endfunction

    function automatic void expect_readout(mta_pkg::out_t o);
      pending_tangents.insert(pending_tangents.size(), o);
    endfunction

    function automatic void note_command(mta_pkg::in_t r);
      mta_pkg::vtx_t a, b, c;
      longint e1x, e1y, e1z, e2x, e2y, e2z, du1, dv1, du2, dv2, det, tx, ty, tz;
      logic [63:0] mx, my, mz, m, len;
      mta_pkg::out_t o;
      case (r.command)
        mta_pkg::CMD_LOAD: begin
          verts[r.vertex_index] = '{r.pos_x, r.pos_y, r.pos_z, r.tex_u, r.tex_v};
          sum_x[r.vertex_index] = 0;
          sum_y[r.vertex_index] = 0;
          sum_z[r.vertex_index] = 0;
        end
        mta_pkg::CMD_TRI: begin
          a = verts[r.corner_a];
          b = verts[r.corner_b];
          c = verts[r.corner_c];
          e1x = clip(longint'(b.pos_x) - longint'(a.pos_x), LIM31);
          e1y = clip(longint'(b.pos_y) - longint'(a.pos_y), LIM31);
          e1z = clip(longint'(b.pos_z) - longint'(a.pos_z), LIM31);
          e2x = clip(longint'(c.pos_x) - longint'(a.pos_x), LIM31);
          e2y = clip(longint'(c.pos_y) - longint'(a.pos_y), LIM31);
          e2z = clip(longint'(c.pos_z) - longint'(a.pos_z), LIM31);
          du1 = clip(longint'(b.tex_u) - longint'(a.tex_u), LIM31);
          dv1 = clip(longint'(b.tex_v) - longint'(a.tex_v), LIM31);
          du2 = clip(longint'(c.tex_u) - longint'(a.tex_u), LIM31);
          dv2 = clip(longint'(c.tex_v) - longint'(a.tex_v), LIM31);
          det = du1 * dv2 - du2 * dv1;
          // flat UV mapping contributes nothing
          if (det == 0) begin
            tx = 0; ty = 0; tz = 0;
          end else begin
            tx = quot_q16(dv2 * e1x - dv1 * e2x, det);
            ty = quot_q16(dv2 * e1y - dv1 * e2y, det);
            tz = quot_q16(dv2 * e1z - dv1 * e2z, det);
          end
          // a repeated corner takes the tangent once per listing
          add_tangent(r.corner_a, tx, ty, tz);
          add_tangent(r.corner_b, tx, ty, tz);
          add_tangent(r.corner_c, tx, ty, tz);
        end
        mta_pkg::CMD_READ: begin
          o = '{read_index: r.vertex_index, tangent_x: 0, tangent_y: 0, tangent_z: 0,
                degenerate: 1'b1};
          mx = mag(sum_x[r.vertex_index]);
          my = mag(sum_y[r.vertex_index]);
          mz = mag(sum_z[r.vertex_index]);
          m = (mx > my) ? mx : my;
          if (mz > m) m = mz;
          if (m != 0) begin
            // bring the largest magnitude into [2^29, 2^30)
            while (m >= (64'd1 << 30)) begin
              mx = mx >> 1; my = my >> 1; mz = mz >> 1; m = m >> 1;
            end
            while (m < (64'd1 << 29)) begin
              mx = mx << 1; my = my << 1; mz = mz << 1; m = m << 1;
            end
            len = root(mx * mx + my * my + mz * mz);
            o.tangent_x  = unit_comp(sum_x[r.vertex_index], mx, len);
            o.tangent_y  = unit_comp(sum_y[r.vertex_index], my, len);
            o.tangent_z  = unit_comp(sum_z[r.vertex_index], mz, len);
            o.degenerate = 1'b0;
          end
          expect_readout(o);
        end
        default: ;  // unused code, no effect
      endcase
    endfunction

    function automatic void field(string name, longint e, longint g);
      if (e != g) begin
        errors++;
        $error("%s: expected %0d, got %0d", name, e, g);
      end
    endfunction

    function automatic void check_readout(mta_pkg::out_t got);
      mta_pkg::out_t e;
      if (pending_tangents.size() == 0) begin
        errors++;
        $error("read-out with nothing outstanding: index %0d", got.read_index);
        return;
      end
      e = pending_tangents.pop_front();
      field("read_index", e.read_index, got.read_index);
      field("tangent_x", e.tangent_x, got.tangent_x);
      field("tangent_y", e.tangent_y, got.tangent_y);
      field("tangent_z", e.tangent_z, got.tangent_z);
      field("degenerate", e.degenerate, got.degenerate);
    endfunction
  endclass

  logic clk, rst, start, busy, done;
  mta_pkg::in_t  request;
  mta_pkg::out_t result;

  tangent_scoreboard sb = new();
  int  idle_pct;
  int  quiet;
  bit  loaded[mta_pkg::VERTEX_COUNT];
  int  loaded_list[$];
  int  vert_pool[16];

  mesh_tangent_accumulator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request(request), .done(done), .result(result)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // result monitor and no-progress watchdog
  always @(posedge clk) begin
    if (rst) begin
      quiet <= 0;
    end else begin
      if (done) sb.check_readout(result);
      if ((start && !busy) || done) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
          $display("mesh_tangent_accumulator_tb: done, errors");
          $finish;
        end
      end
    end
  end

  // Q16.16 coordinate: full range, rails, or small values around zero
  function automatic logic [31:0] coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'($urandom_range(0, 7)) - 32'd3;
      default: return 32'($urandom_range(0, 2097152)) - 32'd1048576;
    endcase
  endfunction

  // unused fields carry noise
  function automatic mta_pkg::in_t noise(logic [1:0] cmd);
    mta_pkg::in_t r;
    logic [223:0] bits;
    bits = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
            $urandom()};
    r = bits[$bits(mta_pkg::in_t)-1:0];
    r.command = cmd;
    return r;
  endfunction

  function automatic mta_pkg::in_t load_cmd(int idx, logic [31:0] px, py, pz, u, v);
    mta_pkg::in_t r;
    r = noise(mta_pkg::CMD_LOAD);
    r.vertex_index = 10'(idx);
    r.pos_x = px; r.pos_y = py; r.pos_z = pz; r.tex_u = u; r.tex_v = v;
    if (!loaded[idx]) begin
      loaded[idx] = 1'b1;
      loaded_list.insert(loaded_list.size(), idx);
    end
    return r;
  endfunction

  function automatic mta_pkg::in_t tri_cmd(int a, b, c);
    mta_pkg::in_t r;
    r = noise(mta_pkg::CMD_TRI);
    r.corner_a = 10'(a); r.corner_b = 10'(b); r.corner_c = 10'(c);
    return r;
  endfunction

  function automatic mta_pkg::in_t read_cmd(int idx);
    mta_pkg::in_t r;
    r = noise(mta_pkg::CMD_READ);
    r.vertex_index = 10'(idx);
    return r;
  endfunction

  // Offers one command and holds it until the block takes it.
  task automatic send(mta_pkg::in_t r);
    request <= r;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(r);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // hold off until every outstanding read-out has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_tangents.size() != 0) @(posedge clk);
  endtask

  function automatic int pick_loaded();
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  function automatic mta_pkg::in_t random_cmd();
    int k, idx;
    k = $urandom_range(0, 99);
    if (k < 30) begin
      idx = ($urandom_range(0, 1)) ? vert_pool[$urandom_range(0, 15)] : $urandom_range(0, 1023);
      return load_cmd(idx, coord(), coord(), coord(), coord(), coord());
    end
    if (k < 70) begin
      if ($urandom_range(0, 9) == 0) begin
        idx = pick_loaded();
        return tri_cmd(idx, idx, pick_loaded());
      end
      return tri_cmd(pick_loaded(), pick_loaded(), pick_loaded());
    end
    if (k < 95) return read_cmd(($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                                            : pick_loaded());
    return noise(CMD_SPARE);
  endfunction

  initial begin
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    idle_pct = 0;
    foreach (vert_pool[i]) vert_pool[i] = $urandom_range(0, 1023);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: rails, unit tangent, flat UVs, repeated corners, clear on load
    send(load_cmd(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF));
    send(load_cmd(1023, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000));
    send(load_cmd(1, 32'h0001_0000, 0, 0, 32'h0001_0000, 0));
    send(load_cmd(2, 0, 32'h0001_0000, 0, 0, 32'h0001_0000));
    send(load_cmd(3, 0, 0, 0, 0, 0));
    send(tri_cmd(3, 1, 2));
    send(read_cmd(3));
    send(read_cmd(1));
    send(tri_cmd(3, 3, 3));
    send(tri_cmd(3, 1, 1));
    send(tri_cmd(1, 3, 2));
    send(tri_cmd(0, 1023, 1));
    send(tri_cmd(1023, 0, 2));
    send(tri_cmd(0, 1023, 3));
    send(read_cmd(0));
    send(read_cmd(1023));
    send(read_cmd(2));
    send(read_cmd(500));
    send(noise(CMD_SPARE));
    send(load_cmd(3, $urandom(), $urandom(), $urandom(), $urandom(), $urandom()));
    send(read_cmd(3));
    send(load_cmd(4, 32'hFFFF_0000, 32'h0000_8000, 32'h0003_0000, 32'h0000_4000,
                  32'hFFFF_C000));
    send(tri_cmd(4, 2, 1));
    send(read_cmd(4));
    drain();

    // random traffic in three idling regimes, each with a full drain midway
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 7 : (phase == 1) ? 69 : 0;
      for (int n = 0; n < 400; n++) begin
        if (n == 200) drain();
        send(random_cmd());
      end
    end
    start <= 1'b0;

    while (sb.pending_tangents.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (sb.errors == 0) begin
      $display("mesh_tangent_accumulator_tb: done, clean");
    end else begin
      $display("mesh_tangent_accumulator_tb: done, errors");
    end
    $finish;
  end

endmodule
